[sv/msts_pkg.sv]
// ----------------------------------------------------------------------------
// msts_pkg
// Shared types and constants for the motion-to-scroll scaler: event codes,
// register map, configuration bundle and divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package msts_pkg;

	// event codes
	localparam logic [2:0] CODE_X      = 3'd0;
	localparam logic [2:0] CODE_Y      = 3'd1;
	localparam logic [2:0] CODE_WHEEL  = 3'd2;
	localparam logic [2:0] CODE_HWHEEL = 3'd3;

	// register map, index is paddr[3:2]
	localparam int          ADDR_W      = 4;
	localparam logic [1:0]  REG_LAYER   = 2'd0;
	localparam logic [1:0]  REG_DIVISOR = 2'd1;
	localparam logic [1:0]  REG_TIMEOUT = 2'd2;

	// register reset and default values
	localparam logic [7:0]  DEFAULT_DIVISOR = 8'd12;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd150;

	// width of residual plus motion sum
	localparam int ACC_W = 33;

	typedef struct packed {
		logic [4:0]  layer_select;
		logic [7:0]  scroll_divisor;
		logic [15:0] idle_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             neg;
		logic [ACC_W-1:0] mag;
	} div_res_t;

endpackage

`default_nettype wire

[sv/motion_to_scroll_scaler.sv]
// ----------------------------------------------------------------------------
// motion_to_scroll_scaler
// Converts relative pointer motion into scroll-wheel steps.
//
// Input channel in_valid/in_ready carries one event word; output channel
// out_valid/out_ready returns exactly one result word per event (forward low
// marks a dropped zero step). Configuration through the APB-style port:
// 0x0 layer select, 0x4 scroll divisor, 0x8 idle timeout in ms.
// An X or Y motion word runs from accept to the next accept through setup, the
// serial divider working through the quotient bit by bit, saturation, a
// multiply and the residual update. Every other word goes from setup straight
// to emit. in_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next word is taken while a
// result still waits; if the receiver stalls, a second result holds in the
// sequencer until the output register frees.
// Reset clears residuals and the last event time, and loads the registers
// with layer select 0, divisor 0 (default of 12) and timeout 150.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_to_scroll_scaler
	import msts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// event input
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              is_relative,
	input  wire logic [2:0]        event_code,
	input  wire logic signed [15:0] motion_value,
	input  wire logic [31:0]       time_ms,
	input  wire logic [31:0]       active_layers,
	// result output
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             out_code,
	output logic signed [15:0]     out_value,
	output logic                   forward,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_START = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_UPD   = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	cfg_t     cfg;
	div_res_t div_res;

	logic [2:0]              state_q;
	// captured word
	logic                    rel_q;
	logic [2:0]              code_q;
	logic signed [15:0]      raw_q;
	logic [31:0]             now_q;
	logic [31:0]             layers_q;
	// state
	logic signed [31:0]      resid_h_q;
	logic signed [31:0]      resid_v_q;
	logic [31:0]             last_time_q;
	// working registers
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0]      q_q;
	logic signed [24:0]      prod_q;
	// pending result and output register
	logic [2:0]              res_code_q;
	logic signed [15:0]      res_value_q;
	logic                    res_fwd_q;
	logic                    out_valid_q;
	logic [2:0]              out_code_q;
	logic signed [15:0]      out_value_q;
	logic                    forward_q;

	logic                    layer_ok;
	logic                    proc;
	logic                    conv;
	logic [31:0]             gap;
	logic                    timed_out;
	logic [7:0]              div_eff;
	logic signed [16:0]      v_clamp;
	logic signed [16:0]      addend;
	logic signed [ACC_W-1:0] resid_sel;
	logic                    sat;
	logic [14:0]             q_mag;
	logic signed [ACC_W-1:0] resid_new;
	logic                    out_free;
	logic                    div_start;

	msts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (div_eff),
		.res      (div_res)
	);

	// event classification
	assign layer_ok  = (cfg.layer_select == 5'd0) || layers_q[cfg.layer_select];
	assign proc      = rel_q && layer_ok && (code_q != CODE_WHEEL)
	                   && (code_q != CODE_HWHEEL);
	assign conv      = proc && ((code_q == CODE_X) || (code_q == CODE_Y));
	assign gap       = now_q - last_time_q;
	assign timed_out = gap > {16'd0, cfg.idle_timeout_ms};
	assign div_eff   = (cfg.scroll_divisor == 8'd0) ? DEFAULT_DIVISOR : cfg.scroll_divisor;

	// motion clamp, y axis negated
	assign v_clamp   = (raw_q == 16'sh8000) ? 17'sh18001 : {raw_q[15], raw_q};
	assign addend    = (code_q == CODE_X) ? v_clamp : -v_clamp;
	assign resid_sel = (code_q == CODE_X) ? {resid_h_q[31], resid_h_q}
	                                      : {resid_v_q[31], resid_v_q};

	// quotient saturation to +/-32767
	assign sat       = |div_res.mag[ACC_W-1:15];
	assign q_mag     = sat ? 15'h7fff : div_res.mag[14:0];
	assign resid_new = acc_q - {{(ACC_W-25){prod_q[24]}}, prod_q};

	assign out_free  = !out_valid_q || out_ready;
	assign div_start = (state_q == ST_START);
	assign in_ready  = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			resid_h_q   <= '0;
			resid_v_q   <= '0;
			last_time_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					if (proc) begin
						last_time_q <= now_q;
						if (timed_out) begin
							resid_h_q <= '0;
							resid_v_q <= '0;
						end
					end
					state_q <= conv ? ST_ADD : ST_EMIT;
				end
				ST_ADD:   state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_res.done) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_UPD;
				ST_UPD: begin
					if (code_q == CODE_X) resid_h_q <= resid_new[31:0];
					else resid_v_q <= resid_new[31:0];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			rel_q    <= is_relative;
			code_q   <= event_code;
			raw_q    <= motion_value;
			now_q    <= time_ms;
			layers_q <= active_layers;
		end
		if (state_q == ST_PREP) begin
			res_code_q  <= code_q;
			res_value_q <= raw_q;
			res_fwd_q   <= 1'b1;
		end
		if (state_q == ST_ADD) begin
			acc_q <= resid_sel + {{(ACC_W-17){addend[16]}}, addend};
		end
		if (state_q == ST_DIV && div_res.done) begin
			q_q <= div_res.neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		end
		if (state_q == ST_MUL) begin
			prod_q <= 25'(q_q * $signed({1'b0, div_eff}));
		end
		if (state_q == ST_UPD) begin
			res_code_q  <= (code_q == CODE_X) ? CODE_HWHEEL : CODE_WHEEL;
			res_value_q <= q_q;
			res_fwd_q   <= (q_q != 16'sd0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_code_q  <= res_code_q;
			out_value_q <= res_value_q;
			forward_q   <= res_fwd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;
	assign out_value = out_value_q;
	assign forward   = forward_q;

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !forward_q |-> (out_value_q == 16'sd0)
		&& ((out_code_q == CODE_WHEEL) || (out_code_q == CODE_HWHEEL)))
		else $error("dropped word is not a zero wheel step");

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_res.busy)
		else $error("divider busy while sequencer idle");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while one is in work");

endmodule

`default_nettype wire

[sv/msts_regs.sv]
// ----------------------------------------------------------------------------
// msts_regs
// APB-style configuration registers: layer select, scroll divisor and idle
// timeout, with read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_regs
	import msts_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_select    <= '0;
			cfg_q.scroll_divisor  <= '0;
			cfg_q.idle_timeout_ms <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_LAYER:   cfg_q.layer_select    <= pwdata[4:0];
				REG_DIVISOR: cfg_q.scroll_divisor  <= pwdata[7:0];
				REG_TIMEOUT: cfg_q.idle_timeout_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		unique case (idx)
			REG_LAYER:   prdata = {27'd0, cfg_q.layer_select};
			REG_DIVISOR: prdata = {24'd0, cfg_q.scroll_divisor};
			REG_TIMEOUT: prdata = {16'd0, cfg_q.idle_timeout_ms};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[sv/msts_div.sv]
// ----------------------------------------------------------------------------
// msts_div
// Serial restoring divider: signed dividend by an 8-bit unsigned divisor,
// one quotient bit a cycle, returns quotient magnitude and sign.
// ----------------------------------------------------------------------------
`default_nettype none

module msts_div
	import msts_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [ACC_W-1:0] dividend,
	input  wire logic        [7:0]       divisor,
	output div_res_t                     res
);

	localparam int CNT_W = $clog2(ACC_W);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rem_q;
	logic [7:0]       div_q;
	logic [ACC_W-1:0] quo_q;
	logic [ACC_W-1:0] abs_in;
	logic [8:0]       shifted;
	logic [9:0]       trial;
	logic             qbit;

	assign abs_in  = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
	assign shifted = {rem_q, quo_q[ACC_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};
	assign qbit    = !trial[9];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, one quotient bit a step
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			neg_q <= dividend[ACC_W-1];
			quo_q <= abs_in;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[7:0] : shifted[7:0];
			quo_q <= {quo_q[ACC_W-2:0], qbit};
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.neg  = neg_q;
	assign res.mag  = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q)
		else $error("divider did not go busy after start");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q && !busy_q)
		else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire
